FILE: hdl/v3alu_pkg.sv
// ----------------------------------------------------------------------------
// v3alu_pkg
// Shared constants and the action codes of the three-component vector ALU.
// ----------------------------------------------------------------------------
`default_nettype none
package v3alu_pkg;
    localparam int FRAC_BITS_DEFAULT = 16;
    localparam int unsigned TOL_RESET = 7;
    localparam logic [3:0] ACT_ADD   = 4'd0;
    localparam logic [3:0] ACT_SUB   = 4'd1;
    localparam logic [3:0] ACT_SCALE = 4'd2;
    localparam logic [3:0] ACT_DIV   = 4'd3;
    localparam logic [3:0] ACT_DOT   = 4'd4;
    localparam logic [3:0] ACT_CROSS = 4'd5;
    localparam logic [3:0] ACT_LEN   = 4'd6;
    localparam logic [3:0] ACT_NORM  = 4'd7;
    localparam logic [3:0] ACT_EQUAL = 4'd8;

    // Clamp a 72-bit signed value to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
        logic signed [31:0] r;
        if (v > 72'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -72'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction
endpackage
`default_nettype wire

FILE: hdl/v3alu_lane.sv
// ----------------------------------------------------------------------------
// v3alu_lane
// One component lane: quotient A * 2^F / d, restoring divide, one bit a stage.
// ----------------------------------------------------------------------------
`default_nettype none
module v3alu_lane #(
    parameter int FRAC_BITS = v3alu_pkg::FRAC_BITS_DEFAULT
) (
    input  wire logic               clk,
    input  wire logic               en,
    input  wire logic signed [31:0] num,
    input  wire logic signed [33:0] den,
    output logic signed [71:0]      quo
);
    localparam int NW = 32 + FRAC_BITS;
    logic [NW-1:0] n_reg [0:NW];
    logic [NW-1:0] q_reg [0:NW];
    logic [NW:0]   r_reg [0:NW];
    logic [32:0]   d_reg [0:NW];
    logic          neg_reg [0:NW];
    logic [31:0]   an;
    logic [32:0]   dn;
    assign an = num[31] ? 32'(-num) : 32'(num);
    assign dn = den[33] ? 33'(-den) : 33'(den);

    // Each stage retires one quotient bit, so one request enters every cycle that en is high.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg[0]   <= {an, {FRAC_BITS{1'b0}}};
            q_reg[0]   <= '0;
            r_reg[0]   <= '0;
            d_reg[0]   <= dn;
            neg_reg[0] <= num[31] ^ den[33];
        end
    end

    for (genvar k = 0; k < NW; k++)
    begin : g_st
        logic [NW:0] t;
        assign t = {r_reg[k][NW-1:0], n_reg[k][NW-1-k]};
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_reg[k+1]   <= n_reg[k];
                d_reg[k+1]   <= d_reg[k];
                neg_reg[k+1] <= neg_reg[k];
                if (t >= (NW+1)'(d_reg[k]))
                begin
                    r_reg[k+1] <= t - (NW+1)'(d_reg[k]);
                    q_reg[k+1] <= q_reg[k] | (NW'(1) << (NW-1-k));
                end
                else
                begin
                    r_reg[k+1] <= t;
                    q_reg[k+1] <= q_reg[k];
                end
            end
        end
    end

    assign quo = neg_reg[NW] ? -$signed({{(72-NW){1'b0}}, q_reg[NW]})
                             :  $signed({{(72-NW){1'b0}}, q_reg[NW]});
endmodule
`default_nettype wire

FILE: hdl/v3alu_sqrt.sv
// ----------------------------------------------------------------------------
// v3alu_sqrt
// Pipelined integer square root of a 66-bit sum, one result bit a stage.
// ----------------------------------------------------------------------------
`default_nettype none
module v3alu_sqrt (
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [65:0] v,
    output logic [32:0]      root
);
    logic [65:0] v_reg [0:33];
    logic [67:0] rem_reg [0:33];
    logic [32:0] q_reg [0:33];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_reg[0]   <= v;
            rem_reg[0] <= '0;
            q_reg[0]   <= '0;
        end
    end

    // Digit-by-digit root, two radicand bits per stage.
    for (genvar k = 0; k < 33; k++)
    begin : g_st
        logic [67:0] t;
        logic [67:0] trial;
        assign t     = {rem_reg[k][65:0], v_reg[k][65-2*k -: 2]};
        assign trial = {33'd0, q_reg[k], 2'b01};
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                v_reg[k+1] <= v_reg[k];
                if (t >= trial)
                begin
                    rem_reg[k+1] <= t - trial;
                    q_reg[k+1]   <= {q_reg[k][31:0], 1'b1};
                end
                else
                begin
                    rem_reg[k+1] <= t;
                    q_reg[k+1]   <= {q_reg[k][31:0], 1'b0};
                end
            end
        end
    end
    assign root = q_reg[33];
endmodule
`default_nettype wire

FILE: hdl/vector3_fixed_point_alu.sv
// ----------------------------------------------------------------------------
// vector3_fixed_point_alu
// Three-component Q-format vector ALU with saturating results.
// ----------------------------------------------------------------------------
// Usage: a request on the input channel (in_valid, in_stall) carries an
// action, vectors A and B and a scalar; one result leaves on the output
// channel (out_valid, out_stall) per request, in order. One request is
// accepted every cycle that the pipe is not stalled. The whole datapath
// is a single pipeline that advances only when its result register is
// empty or being taken. A request passes through the input register, 34
// square root registers, a length register, 33+FRAC_BITS divider registers
// (all but the first retire one quotient bit; FRAC_BITS is 16 at the
// Q16.16 default) and the result register. While the receiver stalls the
// whole pipe holds, and in_stall is raised only when the result register
// is full and stalled. Reset empties the pipe and sets the tolerance to 7.
// The tolerance register is written over cfg_valid/cfg_ready, always ready.
// ----------------------------------------------------------------------------
`default_nettype none
module vector3_fixed_point_alu #(
    parameter int FRAC_BITS = v3alu_pkg::FRAC_BITS_DEFAULT
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [3:0]         action,
    input  wire logic signed [31:0] ax,
    input  wire logic signed [31:0] ay,
    input  wire logic signed [31:0] az,
    input  wire logic signed [31:0] bx,
    input  wire logic signed [31:0] by,
    input  wire logic signed [31:0] bz,
    input  wire logic signed [31:0] scalar_in,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [31:0]      rx,
    output logic signed [31:0]      ry,
    output logic signed [31:0]      rz,
    output logic signed [31:0]      scalar_out,
    output logic                    is_equal,
    output logic                    zero_divisor,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [15:0]        cfg_data
);
    localparam int DIVL = 32 + FRAC_BITS;
    localparam int SQL  = 33;
    localparam int DEPTH = 3 + SQL + DIVL;

    typedef struct packed {
        logic [3:0]         act;
        logic signed [31:0] ax, ay, az;
        logic signed [71:0] r0, r1, r2;
        logic               eq;
        logic signed [33:0] s;
    } stage_t;

    logic [15:0] tol_reg;
    logic        en;
    logic [DEPTH+1:0] v_reg;
    stage_t      p_reg [0:DEPTH];
    logic [32:0] root;
    logic signed [71:0] q0, q1, q2;

    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tol_reg <= 16'(v3alu_pkg::TOL_RESET);
        else if (cfg_valid)
            tol_reg <= cfg_data;
    end

    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    // Valid bits of the pipe, including the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[DEPTH:0], in_valid};
    end

    // Stage 0: exact products, sums and compares.
    logic signed [63:0] pxx, pyy, pzz, m0, m1, m2, m3, m4, m5, sx, sy, sz;
    logic signed [63:0] ssx, ssy, ssz;
    logic signed [33:0] tl;
    logic               e0;
    assign pxx = ax * bx;  assign pyy = ay * by;  assign pzz = az * bz;
    assign m0 = ay * bz;   assign m1 = az * by;   assign m2 = az * bx;
    assign m3 = ax * bz;   assign m4 = ax * by;   assign m5 = ay * bx;
    assign sx = ax * scalar_in; assign sy = ay * scalar_in; assign sz = az * scalar_in;
    assign ssx = ax * ax;  assign ssy = ay * ay;  assign ssz = az * az;
    assign tl = $signed({18'd0, tol_reg});
    assign e0 = (34'(ax) - tl <= 34'(bx)) && (34'(ax) <= 34'(bx) + tl)
             && (34'(ay) - tl <= 34'(by)) && (34'(ay) <= 34'(by) + tl)
             && (34'(az) - tl <= 34'(bz)) && (34'(az) <= 34'(bz) + tl);

    stage_t s0;
    always_comb
    begin
        s0 = '0;
        s0.act = action; s0.ax = ax; s0.ay = ay; s0.az = az;
        s0.eq  = e0;
        s0.s   = 34'(scalar_in);
        case (action) inside
            v3alu_pkg::ACT_ADD:
            begin
                s0.r0 = 72'(ax) + 72'(bx); s0.r1 = 72'(ay) + 72'(by);
                s0.r2 = 72'(az) + 72'(bz);
            end
            v3alu_pkg::ACT_SUB:
            begin
                s0.r0 = 72'(ax) - 72'(bx); s0.r1 = 72'(ay) - 72'(by);
                s0.r2 = 72'(az) - 72'(bz);
            end
            v3alu_pkg::ACT_SCALE:
            begin
                s0.r0 = 72'(sx); s0.r1 = 72'(sy); s0.r2 = 72'(sz);
            end
            v3alu_pkg::ACT_DOT:
                s0.r0 = 72'(pxx) + 72'(pyy) + 72'(pzz);
            v3alu_pkg::ACT_CROSS:
            begin
                s0.r0 = 72'(m0) - 72'(m1); s0.r1 = 72'(m2) - 72'(m3);
                s0.r2 = 72'(m4) - 72'(m5);
            end
            v3alu_pkg::ACT_LEN, v3alu_pkg::ACT_NORM:
                s0.r0 = 72'(ssx) + 72'(ssy) + 72'(ssz);
            default: ;
        endcase
    end

    // Delay line; the length register takes the root as it leaves the sqrt pipe.
    v3alu_sqrt u_sqrt (
        .clk(clk), .en(en), .v(66'(p_reg[0].r0)), .root(root)
    );
    stage_t sq;
    always_comb
    begin
        sq = p_reg[SQL+1];
        if (p_reg[SQL+1].act == v3alu_pkg::ACT_LEN
            || p_reg[SQL+1].act == v3alu_pkg::ACT_NORM)
            sq.s = 34'(root);
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg[0] <= s0;
            for (int k = 1; k <= DEPTH; k++)
            begin
                if (k == SQL + 2)
                    p_reg[k] <= sq;
                else
                    p_reg[k] <= p_reg[k-1];
            end
        end
    end

    // Divider lanes, one per component; divisor is the scalar or the length.
    v3alu_lane #(.FRAC_BITS(FRAC_BITS)) u_l0 (
        .clk(clk), .en(en), .num(p_reg[SQL+2].ax), .den(p_reg[SQL+2].s), .quo(q0));
    v3alu_lane #(.FRAC_BITS(FRAC_BITS)) u_l1 (
        .clk(clk), .en(en), .num(p_reg[SQL+2].ay), .den(p_reg[SQL+2].s), .quo(q1));
    v3alu_lane #(.FRAC_BITS(FRAC_BITS)) u_l2 (
        .clk(clk), .en(en), .num(p_reg[SQL+2].az), .den(p_reg[SQL+2].s), .quo(q2));

    // Rounding of product sums: floor((v + half) / 2^F).
    function automatic logic signed [71:0] rnd(input logic signed [71:0] v);
        logic signed [71:0] t;
        t = v + (72'sd1 <<< (FRAC_BITS - 1));
        return t >>> FRAC_BITS;
    endfunction

    // Merge stage: choose each output by action and saturate.
    stage_t f;
    logic   dz;
    logic signed [31:0] rx_next, ry_next, rz_next, sc_next;
    logic               eq_next, zd_next;
    assign f  = p_reg[DEPTH];
    assign dz = (f.s == '0);
    always_comb
    begin
        rx_next = '0; ry_next = '0; rz_next = '0; sc_next = '0;
        eq_next = 1'b0; zd_next = 1'b0;
        case (f.act) inside
            v3alu_pkg::ACT_ADD, v3alu_pkg::ACT_SUB:
            begin
                rx_next = v3alu_pkg::sat32(f.r0); ry_next = v3alu_pkg::sat32(f.r1);
                rz_next = v3alu_pkg::sat32(f.r2);
            end
            v3alu_pkg::ACT_SCALE, v3alu_pkg::ACT_CROSS:
            begin
                rx_next = v3alu_pkg::sat32(rnd(f.r0));
                ry_next = v3alu_pkg::sat32(rnd(f.r1));
                rz_next = v3alu_pkg::sat32(rnd(f.r2));
            end
            v3alu_pkg::ACT_DOT:
                sc_next = v3alu_pkg::sat32(rnd(f.r0));
            v3alu_pkg::ACT_LEN:
                sc_next = v3alu_pkg::sat32(72'(f.s));
            v3alu_pkg::ACT_DIV, v3alu_pkg::ACT_NORM:
            begin
                if (dz)
                    zd_next = 1'b1;
                else
                begin
                    rx_next = v3alu_pkg::sat32(q0); ry_next = v3alu_pkg::sat32(q1);
                    rz_next = v3alu_pkg::sat32(q2);
                    if (f.act == v3alu_pkg::ACT_NORM)
                        sc_next = v3alu_pkg::sat32(72'(f.s));
                end
            end
            v3alu_pkg::ACT_EQUAL:
                eq_next = f.eq;
            default: ;
        endcase
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rx <= rx_next; ry <= ry_next; rz <= rz_next; scalar_out <= sc_next;
            is_equal <= eq_next; zero_divisor <= zd_next;
        end
    end
    assign out_valid = v_reg[DEPTH+1];
endmodule
`default_nettype wire

FILE: verif/vector3_fixed_point_alu_tb.sv
// ----------------------------------------------------------------------------
// vector3_fixed_point_alu_tb
// Self-checking bench for the three-component fixed-point vector ALU. Each
// request is predicted in a scoreboard class, and every result is checked
// field by field, in order. Stimulus is a directed set of edge cases followed
// by random requests under several tolerance settings, with random idling on
// both channels.
// ----------------------------------------------------------------------------
`default_nettype none
module vector3_fixed_point_alu_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = 16;
    localparam int PIPE_DEPTH = 2 * (32 + FRAC) + 40;
    localparam int WATCHDOG_LIMIT = 20 * PIPE_DEPTH;

    typedef struct {
        logic [3:0]         action;
        logic signed [31:0] av [3];
        logic signed [31:0] bv [3];
        logic signed [31:0] scalar;
    } vec_request_t;

    typedef struct {
        logic signed [31:0] rx;
        logic signed [31:0] ry;
        logic signed [31:0] rz;
        logic signed [31:0] sc;
        logic               eq;
        logic               zd;
    } vec_result_t;

    // Holds the tolerance and the queue of predicted results.
    class vec_alu_scoreboard;
        logic [15:0]  tolerance;
        vec_result_t  pending_results [$];
        int           mismatches;
        int           checked;

        function new();
            tolerance  = 16'(v3alu_pkg::TOL_RESET);
            mismatches = 0;
            checked    = 0;
        endfunction

        // Clamp a wide signed value to the signed 32-bit range.
        function logic signed [31:0] clamp(input logic signed [71:0] v);
            if (v > 72'sd2147483647)
                return 32'sh7fffffff;
            if (v < -72'sd2147483648)
                return 32'sh80000000;
            return v[31:0];
        endfunction

        // Divide by 2^FRAC, rounding to nearest with ties upwards.
        function logic signed [71:0] round_frac(input logic signed [71:0] v);
            return (v + (72'sd1 <<< (FRAC - 1))) >>> FRAC;
        endfunction

        function logic [63:0] int_sqrt(input logic [63:0] v);
            logic [63:0] res;
            logic [63:0] bitv;
            res  = 0;
            bitv = 64'd1 << 62;
            while (bitv > v)
                bitv = bitv >> 2;
            while (bitv != 0)
            begin
                if (v >= res + bitv)
                begin
                    v   = v - (res + bitv);
                    res = (res >> 1) + bitv;
                end
                else
                    res = res >> 1;
                bitv = bitv >> 2;
            end
            return res;
        endfunction

        function vec_result_t predict(input vec_request_t rq);
            vec_result_t        r;
            logic signed [71:0] a [3];
            logic signed [71:0] b [3];
            logic signed [71:0] s;
            logic signed [71:0] w [3];
            logic signed [71:0] tol;
            logic [63:0]        sumsq;
            logic [63:0]        len;
            for (int i = 0; i < 3; i++)
            begin
                a[i] = rq.av[i];
                b[i] = rq.bv[i];
                w[i] = 0;
            end
            s     = rq.scalar;
            tol   = {56'd0, tolerance};
            r     = '{default: '0};
            sumsq = 0;
            for (int i = 0; i < 3; i++)
                sumsq = sumsq + 64'(a[i] * a[i]);
            len = int_sqrt(sumsq);
            case (rq.action)
                v3alu_pkg::ACT_ADD:
                    for (int i = 0; i < 3; i++) w[i] = a[i] + b[i];
                v3alu_pkg::ACT_SUB:
                    for (int i = 0; i < 3; i++) w[i] = a[i] - b[i];
                v3alu_pkg::ACT_SCALE:
                    for (int i = 0; i < 3; i++) w[i] = round_frac(a[i] * s);
                v3alu_pkg::ACT_DIV:
                    if (s == 0)
                        r.zd = 1'b1;
                    else
                        for (int i = 0; i < 3; i++) w[i] = (a[i] <<< FRAC) / s;
                v3alu_pkg::ACT_DOT:
                    r.sc = clamp(round_frac(a[0] * b[0] + a[1] * b[1] + a[2] * b[2]));
                v3alu_pkg::ACT_CROSS:
                begin
                    w[0] = round_frac(a[1] * b[2] - a[2] * b[1]);
                    w[1] = round_frac(a[2] * b[0] - a[0] * b[2]);
                    w[2] = round_frac(a[0] * b[1] - a[1] * b[0]);
                end
                v3alu_pkg::ACT_LEN:
                    r.sc = clamp({8'd0, len});
                v3alu_pkg::ACT_NORM:
                    if (len == 0)
                        r.zd = 1'b1;
                    else
                    begin
                        for (int i = 0; i < 3; i++)
                            w[i] = (a[i] <<< FRAC) / $signed({8'd0, len});
                        r.sc = clamp({8'd0, len});
                    end
                v3alu_pkg::ACT_EQUAL:
                begin
                    r.eq = 1'b1;
                    for (int i = 0; i < 3; i++)
                        if (!(a[i] - tol <= b[i] && a[i] <= b[i] + tol))
                            r.eq = 1'b0;
                end
                default: ;
            endcase
            r.rx = clamp(w[0]);
            r.ry = clamp(w[1]);
            r.rz = clamp(w[2]);
            return r;
        endfunction

        function void note_request(input vec_request_t rq);
            pending_results.push_back(predict(rq));
        endfunction

        function void check_result(input vec_result_t got);
            vec_result_t want;
            if (pending_results.size() == 0)
            begin
                $error("result with no request outstanding");
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            checked++;
            if (got.rx !== want.rx)
            begin
                $error("rx: expected %0d, actual %0d", want.rx, got.rx);
                mismatches++;
            end
            if (got.ry !== want.ry)
            begin
                $error("ry: expected %0d, actual %0d", want.ry, got.ry);
                mismatches++;
            end
            if (got.rz !== want.rz)
            begin
                $error("rz: expected %0d, actual %0d", want.rz, got.rz);
                mismatches++;
            end
            if (got.sc !== want.sc)
            begin
                $error("scalar_out: expected %0d, actual %0d", want.sc, got.sc);
                mismatches++;
            end
            if (got.eq !== want.eq)
            begin
                $error("is_equal: expected %0b, actual %0b", want.eq, got.eq);
                mismatches++;
            end
            if (got.zd !== want.zd)
            begin
                $error("zero_divisor: expected %0b, actual %0b", want.zd, got.zd);
                mismatches++;
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [3:0]         action = '0;
    logic signed [31:0] ax = '0, ay = '0, az = '0;
    logic signed [31:0] bx = '0, by = '0, bz = '0;
    logic signed [31:0] scalar_in = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [31:0] rx, ry, rz, scalar_out;
    logic               is_equal, zero_divisor;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [15:0]        cfg_data = '0;

    vec_alu_scoreboard sb = new();
    bit                calm = 1'b0;
    int                idle_cycles = 0;
    int                action_count [16];
    int                tol_writes = 0;

    vector3_fixed_point_alu #(.FRAC_BITS(FRAC)) u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .action(action), .ax(ax), .ay(ay), .az(az),
        .bx(bx), .by(by), .bz(bz), .scalar_in(scalar_in),
        .out_valid(out_valid), .out_stall(out_stall),
        .rx(rx), .ry(ry), .rz(rz), .scalar_out(scalar_out),
        .is_equal(is_equal), .zero_divisor(zero_divisor),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #1 clk = ~clk;

    // Accepted requests are predicted, accepted results are checked.
    always @(posedge clk)
    begin
        vec_request_t rq;
        vec_result_t  rs;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                rq.action = action;
                rq.av[0] = ax; rq.av[1] = ay; rq.av[2] = az;
                rq.bv[0] = bx; rq.bv[1] = by; rq.bv[2] = bz;
                rq.scalar = scalar_in;
                sb.note_request(rq);
                action_count[action]++;
            end
            if (out_valid && !out_stall)
            begin
                rs.rx = rx; rs.ry = ry; rs.rz = rz; rs.sc = scalar_out;
                rs.eq = is_equal; rs.zd = zero_divisor;
                sb.check_result(rs);
            end
        end
    end

    // The receiver stalls in random bursts until the calm part of the run.
    always @(negedge clk)
    begin
        int burst;
        if (burst > 0)
        begin
            burst--;
            out_stall <= 1'b1;
        end
        else if (!calm && $urandom_range(0, 9) == 0)
        begin
            burst = $urandom_range(0, 11);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // Watchdog on cycles in which neither channel moves a request and cfg_valid is low.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_valid)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog expired with %0d results outstanding",
                         sb.pending_results.size());
                $display("FAIL");
                $finish;
            end
        end
    end

    function automatic logic signed [31:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 32'sh7fffffff;
            1:       return 32'sh80000000;
            2:       return 32'sd0;
            3:       return $signed($urandom_range(0, 15)) - 32'sd8;
            4, 5, 6: return $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
            default: return $signed($urandom());
        endcase
    endfunction

    function automatic vec_request_t random_request();
        vec_request_t rq;
        int           spread;
        rq.action = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15))
                                                 : 4'($urandom_range(0, 8));
        for (int i = 0; i < 3; i++)
        begin
            rq.av[i] = pick_word();
            rq.bv[i] = pick_word();
        end
        rq.scalar = pick_word();
        // Steer toward divide by zero, a zero vector and near-tolerance pairs.
        if (rq.action == v3alu_pkg::ACT_DIV && $urandom_range(0, 4) == 0)
            rq.scalar = 0;
        if (rq.action == v3alu_pkg::ACT_NORM && $urandom_range(0, 4) == 0)
            rq.av = '{0, 0, 0};
        if (rq.action == v3alu_pkg::ACT_EQUAL && $urandom_range(0, 3) != 0)
        begin
            spread = int'(sb.tolerance) + 2;
            for (int i = 0; i < 3; i++)
                rq.bv[i] = rq.av[i] + $signed($urandom_range(0, 2 * spread)) - spread;
        end
        return rq;
    endfunction

    task automatic send_request(input vec_request_t rq);
        int gap;
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 12);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid  <= 1'b1;
        action    <= rq.action;
        ax <= rq.av[0]; ay <= rq.av[1]; az <= rq.av[2];
        bx <= rq.bv[0]; by <= rq.bv[1]; bz <= rq.bv[2];
        scalar_in <= rq.scalar;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic drain_pipe();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 4) @(posedge clk);
    endtask

    // The tolerance is written only once the pipe has emptied.
    task automatic write_tolerance(input logic [15:0] value);
        drain_pipe();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.tolerance = value;
        tol_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic directed_requests();
        vec_request_t rq;
        for (int k = 0; k < 16; k++)
        begin
            rq.action = 4'(k);
            rq.av = '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff};
            rq.bv = '{32'sh80000000, 32'sh7fffffff, 32'sh80000000};
            rq.scalar = (k % 2 == 0) ? 32'sh80000000 : 32'sh7fffffff;
            send_request(rq);
        end
        // Divide by zero.
        rq.action = v3alu_pkg::ACT_DIV; rq.av = '{32'sh10000, -32'sh10000, 5};
        rq.scalar = 0;
        send_request(rq);
        // Divide of the most negative value and of one LSB by minus one LSB.
        rq.av = '{32'sh80000000, 32'sh80000000, 1}; rq.scalar = -1;
        send_request(rq);
        // Normalizing a zero vector.
        rq.action = v3alu_pkg::ACT_NORM; rq.av = '{0, 0, 0};
        send_request(rq);
        // Normalizing a vector of length one LSB.
        rq.av = '{0, -1, 0};
        send_request(rq);
        // Length and normalize of the largest vector.
        rq.action = v3alu_pkg::ACT_LEN;
        rq.av = '{32'sh80000000, 32'sh80000000, 32'sh80000000};
        send_request(rq);
        rq.action = v3alu_pkg::ACT_NORM;
        send_request(rq);
        // Equality exactly at and one beyond the tolerance.
        rq.action = v3alu_pkg::ACT_EQUAL; rq.av = '{100, 100, 100};
        rq.bv = '{107, 93, 100};
        send_request(rq);
        rq.bv = '{108, 100, 100};
        send_request(rq);
        // Scale rounding ties, positive and negative.
        rq.action = v3alu_pkg::ACT_SCALE; rq.av = '{1, -1, 3}; rq.scalar = 32'sh8000;
        send_request(rq);
    endtask

    initial
    begin
        logic [15:0] tol_plan [5];
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        directed_requests();
        tol_plan = '{16'd0, 16'hffff, 16'($urandom()), 16'd1, 16'(v3alu_pkg::TOL_RESET)};
        foreach (tol_plan[p])
        begin
            write_tolerance(tol_plan[p]);
            if (p == 4)
                calm = 1'b1;
            repeat (300) send_request(random_request());
        end
        drain_pipe();

        $display("checked %0d results over %0d tolerance settings", sb.checked, tol_writes + 1);
        $display("dot %0d, cross %0d, divide %0d, normalize %0d, equal %0d requests",
                 action_count[v3alu_pkg::ACT_DOT], action_count[v3alu_pkg::ACT_CROSS],
                 action_count[v3alu_pkg::ACT_DIV], action_count[v3alu_pkg::ACT_NORM],
                 action_count[v3alu_pkg::ACT_EQUAL]);
        if (sb.mismatches == 0 && sb.pending_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
`default_nettype wire
